@@ src/msu_pkg.sv @@
// Shared types and constants for the median-of-sample-set unit.
// No dependencies; imported by msu_cell, median_of_sample_set_unit and the test bench.

package msu_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEDIAN_W = SAMPLE_W + 1;
    localparam int COUNT_W  = 7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEDIAN_W-1:0] median_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic    ins_en;
        sample_t sample;
    } ins_ctrl_t;

    // Link from one cell to its right-hand neighbour.
    typedef struct packed {
        logic    gt;
        sample_t val;
    } link_t;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_FINISH  = 2'b10
    } state_t;

endpackage

@@ src/median_of_sample_set_unit.sv @@
// Top level of the median-of-sample-set unit: insertion-sort cell chain,
// fill/drop bookkeeping, median selection and output register.
// Depends on msu_pkg and msu_cell.
//
//  channel   signals                                  dir   moves
//  -------   --------------------------------------   ---   -----------------------------
//  input     sample_valid, sample_ready, sample, last  in    one sample request per cycle in ST_COLLECT
//  result    result_valid, result_ready, median_x2,    out   one median request per set
//            count, overflow
//
// Sequence: a sample with last low is inserted by the chain in the cycle it
// is accepted. A sample with last high is inserted the same way; then the
// ST_FINISH state picks the middle entries and loads the output register.
// Reset: rst_n clears the fill count, drop flag, state and output valid; the
// cell contents are not reset and are only read below the fill count.
// Stalls: while the output register still holds an untaken result, the
// finishing cycle waits and sample_ready stays low.

module median_of_sample_set_unit
    import msu_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                      last,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [MEDIAN_W-1:0] median_x2,
    output logic [COUNT_W-1:0]        count,
    output logic                      overflow
);

    localparam int FW = $clog2(WINDOW + 1);

    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            drop_reg, drop_next;

    logic            out_valid_reg;
    median_t         median_reg;
    logic [COUNT_W-1:0] count_reg;
    logic            overflow_reg;

    logic            accept;
    logic            full;
    logic            load_out;
    ins_ctrl_t       ctrl;

    logic [WINDOW-1:0] occ;
    link_t           links [WINDOW+1];

    logic [FW-1:0]   half;
    logic [FW-1:0]   idx_hi;
    logic [FW-1:0]   idx_lo;
    sample_t         val_hi;
    sample_t         val_lo;
    median_t         med_sum;

    // Handshake and insert enable: a sample that finds the store full is
    // dropped and only sets the drop flag.
    assign sample_ready = (state_reg == ST_COLLECT);
    assign accept       = sample_valid && sample_ready;
    assign full         = (fill_reg == FW'(WINDOW));
    assign ctrl.ins_en  = accept && !full;
    assign ctrl.sample  = sample;

    // Occupancy as a thermometer code from the fill count.
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            occ[i] = (fill_reg > FW'(i));
        end
    end

    // Cell chain: the left edge never shifts in.
    assign links[0] = '{gt: 1'b0, val: '0};

    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        logic occ_left;
        if (g == 0)
        begin : g_first
            assign occ_left = 1'b1;
        end
        else
        begin : g_rest
            assign occ_left = occ[g-1];
        end

        msu_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .occ_self (occ[g]),
            .occ_left (occ_left),
            .left     (links[g]),
            .right    (links[g+1])
        );
    end

    // Median selection: middle entry for an odd count, the two middle
    // entries for an even count (taken twice for odd, so the sum is 2x).
    always_comb
    begin
        half   = fill_reg >> 1;
        idx_hi = half;
        idx_lo = fill_reg[0] ? half : (half - FW'(1));
        val_hi = '0;
        val_lo = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (idx_hi == FW'(i))
            begin
                val_hi = val_hi | links[i+1].val;
            end
            if (idx_lo == FW'(i))
            begin
                val_lo = val_lo | links[i+1].val;
            end
        end
        med_sum = {val_hi[SAMPLE_W-1], val_hi} + {val_lo[SAMPLE_W-1], val_lo};
    end

    // Finish when the output register is free or being drained.
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                    if (last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    fill_next  = '0;
                    drop_next  = 1'b0;
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
        end
    end

    // Output register: hold until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg   <= med_sum;
            count_reg    <= COUNT_W'(fill_reg);
            overflow_reg <= drop_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign median_x2    = median_reg;
    assign count        = count_reg;
    assign overflow     = overflow_reg;

    // Checks.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW))
        else $error("fill count beyond window");

    a_finish_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |-> fill_reg != '0)
        else $error("finishing an empty set");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished set");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow) |-> count == COUNT_W'(WINDOW))
        else $error("drop flagged on a set below the window");

endmodule

@@ src/msu_cell.sv @@
// One sorting cell of the insertion chain: holds a single stored sample.
// Depends on msu_pkg (ins_ctrl_t, link_t, sample_t).

module msu_cell
    import msu_pkg::*;
(
    input  logic      clk,
    input  ins_ctrl_t ctrl,
    input  logic      occ_self,
    input  logic      occ_left,
    input  link_t     left,
    output link_t     right
);

    sample_t val_reg;
    sample_t val_next;
    logic    gt_self;
    logic    at_end;
    logic    wr;

    // Make room when the new sample sorts below this entry; take the
    // neighbour's entry if it moves up too, else take the new sample.
    always_comb
    begin
        gt_self  = occ_self && (ctrl.sample < val_reg);
        at_end   = !occ_self && occ_left;
        wr       = ctrl.ins_en && (gt_self || at_end);
        val_next = left.gt ? left.val : ctrl.sample;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            val_reg <= val_next;
        end
    end

    assign right.gt  = gt_self;
    assign right.val = val_reg;

endmodule

@@ test/median_of_sample_set_unit_test.sv @@
// Regression bench for median_of_sample_set_unit: directed and random sample sets,
// checked against an in-bench insertion-sort median predictor.
// Depends on msu_pkg and the median_of_sample_set_unit RTL.

module median_of_sample_set_unit_test
    import msu_pkg::*;
();

    localparam int WINDOW     = 16;
    localparam int HALF_CYCLE = 10;
    localparam int HOLD_SPAN  = 300;   // cycles the receiver refuses results
    localparam int SETTLE     = 8;     // wait before the final pending check; allow slack
    localparam int TIMEOUT    = 20 * 400_000;

    typedef struct {
        median_t            med;
        logic [COUNT_W-1:0] cnt;
        logic               ovf;
    } median_res_t;

    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_EDGE
    } val_style_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               sample_valid = 1'b0;
    logic               sample_ready;
    sample_t            sample       = '0;
    logic               last         = 1'b0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    median_t            median_x2;
    logic [COUNT_W-1:0] count;
    logic               overflow;

    // Predictor state: the samples of the open set in ascending order, and
    // whether any sample of that set has been dropped.
    sample_t     held_sorted[$];
    logic        set_dropped = 1'b0;
    median_res_t pending_medians[$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int sets_checked  = 0;
    int overflow_sets = 0;
    int errors        = 0;

    median_of_sample_set_unit #(.WINDOW(WINDOW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .median_x2    (median_x2),
        .count        (count),
        .overflow     (overflow)
    );

    always #HALF_CYCLE clk = ~clk;

    // Fold one accepted sample into the predicted set. On a last sample,
    // queue the expected median and open a fresh set.
    function automatic void absorb_sample(sample_t s, logic is_last);
        int          pos;
        int          n;
        median_res_t res;
        if (held_sorted.size() >= WINDOW)
            set_dropped = 1'b1;          // store full: drop the sample, flag the set
        else
        begin
            // equal samples go after those already held
            pos = held_sorted.size();
            while (pos > 0 && s < held_sorted[pos-1])
                pos--;
            held_sorted.insert(pos, s);
        end
        if (is_last)
        begin
            n = held_sorted.size();
            if (n % 2 == 1)
                res.med = median_t'(held_sorted[n/2]) + median_t'(held_sorted[n/2]);
            else
                res.med = median_t'(held_sorted[n/2]) + median_t'(held_sorted[n/2-1]);
            res.cnt = COUNT_W'(n);
            res.ovf = set_dropped;
            if (set_dropped)
                overflow_sets++;
            pending_medians.push_back(res);
            held_sorted.delete();
            set_dropped = 1'b0;
        end
    endfunction

    function automatic sample_t rand_sample(val_style_t style);
        case (style)
            VAL_NARROW: return sample_t'(int'($urandom_range(8)) - 4);
            VAL_EDGE:
                case ($urandom_range(2))
                    0:       return sample_t'(16'h8000 + $urandom_range(3));
                    1:       return sample_t'(16'h7FFF - $urandom_range(3));
                    default: return sample_t'(int'($urandom_range(2)) - 1);
                endcase
            default:    return sample_t'($urandom);
        endcase
    endfunction

    // Offer one sample request and hold it until accepted. Valid is left high
    // afterwards; whoever waits next lowers it first.
    task automatic send_sample(sample_t s, logic is_last);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        last         <= is_last;
        do @(posedge clk); while (!sample_ready);
        absorb_sample(s, is_last);
        items_sent++;
    endtask

    // Withdraw the sender and hold until every queued median has come back.
    task automatic wait_results_drained();
        sample_valid <= 1'b0;
        do @(posedge clk); while (pending_medians.size() != 0);
    endtask

    // Mostly sets that fit the window; some run past it so samples get dropped.
    task automatic send_random_set();
        int         len;
        int         r;
        val_style_t style;
        r = $urandom_range(99);
        if (r < 12)
            len = $urandom_range(WINDOW + 8, WINDOW + 1);
        else if (r < 25)
            len = $urandom_range(3, 1);
        else
            len = $urandom_range(WINDOW, 1);
        style = val_style_t'($urandom_range(2));
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(style), i == len - 1);
    endtask

    task automatic run_random_phase(int send_idle, int recv_stall, int n_items);
        int start;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        start     = items_sent;
        while (items_sent - start < n_items)
        begin
            send_random_set();
            // now and then let the pipe run dry before the next set
            if ($urandom_range(9) == 0)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    // Extremes of the sample range, equal samples, odd and even sets, set of one.
    task automatic test_directed_edges();
        idle_pct  = 0;
        stall_pct = 0;
        send_sample(sample_t'(16'h8000), 1'b1);
        send_sample(sample_t'(16'h7FFF), 1'b0);
        send_sample(sample_t'(16'h7FFF), 1'b1);
        send_sample(sample_t'(16'h8000), 1'b0);
        send_sample(sample_t'(16'h8000), 1'b1);
        send_sample(sample_t'(3), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(3), 1'b1);
        send_sample(sample_t'(16'h7FFF), 1'b0);
        send_sample(sample_t'(16'h8000), 1'b1);
        wait_results_drained();
    endtask

    // Full store: the seventeenth sample carries last and is itself dropped.
    task automatic test_overflow_set();
        idle_pct  = 0;
        stall_pct = 0;
        for (int i = 0; i <= WINDOW; i++)
            send_sample(rand_sample(VAL_FULL), i == WINDOW);
        wait_results_drained();
    endtask

    task automatic test_no_idling();
        run_random_phase(0, 0, 135);
    endtask

    task automatic test_sender_idle();
        run_random_phase(68, 0, 135);
    endtask

    task automatic test_receiver_stall();
        run_random_phase(0, 68, 135);
    endtask

    task automatic test_both_idle();
        run_random_phase(27, 27, 135);
    endtask

    // Receiver refuses results for a long stretch while short sets keep
    // coming, so the output register fills and sample_ready must drop.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        holds_asked++;
        for (int k = 0; k < 16; k++)
            for (int i = 0; i < 3; i++)
                send_sample(rand_sample(VAL_FULL), i == 2);
        for (int i = 0; i < WINDOW + 4; i++)
            send_sample(rand_sample(VAL_EDGE), i == WINDOW + 3);
        wait_results_drained();
    endtask

    // Result side: random stalls, plus a counted hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = HOLD_SPAN;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each median request taken from the block with the oldest prediction.
    always @(posedge clk)
    begin
        median_res_t want;
        if (rst_n && result_valid && result_ready)
        begin
            sets_checked++;
            if (pending_medians.size() == 0)
            begin
                errors++;
                $error("unexpected result: median_x2 %0d count %0d overflow %0d",
                       median_x2, count, overflow);
            end
            else
            begin
                want = pending_medians.pop_front();
                if (median_x2 !== want.med)
                begin
                    errors++;
                    $error("median_x2: expected %0d, got %0d", want.med, median_x2);
                end
                if (count !== want.cnt)
                begin
                    errors++;
                    $error("count: expected %0d, got %0d", want.cnt, count);
                end
                if (overflow !== want.ovf)
                begin
                    errors++;
                    $error("overflow: expected %0d, got %0d", want.ovf, overflow);
                end
            end
        end
    end

    initial
    begin
        #TIMEOUT;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_overflow_set();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();

        repeat (SETTLE) @(posedge clk);
        if (pending_medians.size() != 0)
        begin
            errors++;
            $error("%0d predicted medians never arrived", pending_medians.size());
        end

        $display("Ran %0d samples in %0d median sets (%0d with dropped samples),",
                 items_sent, sets_checked, overflow_sets);
        $display("under four idle/stall mixes and one long result hold-off.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
